// ===== hw/rtl/fsmt_pkg.sv =====
// package: types, constants and codes shared by the fail-safe mode table
package fsmt_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int WORD_W      = 32;
   localparam int ENTRY_CNT_W = 5;

   localparam logic [1:0] OP_REGISTER = 2'd0;
   localparam logic [1:0] OP_EXECUTE  = 2'd1;
   localparam logic [1:0] OP_LOOKUP   = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  drive_key;
      logic [3:0]  new_supply_fail_mode;
      logic [3:0]  new_link_fail_mode;
      logic [15:0] new_comms_timeout;
      logic        power_lost;
      logic [15:0] comms_elapsed;
   } req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic                   apply_mode;
      logic [3:0]             selected_mode;
      logic [3:0]             found_supply_fail_mode;
      logic [3:0]             found_link_fail_mode;
      logic [15:0]            found_comms_timeout;
      logic [ENTRY_CNT_W-1:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic scan;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic rsp_free;
   } stat_type;

endpackage

// ===== hw/rtl/fsmt_ram.sv =====
// generic single-write, single-read ram with registered read data
module fsmt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                           clock,
   input  logic                                           we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
   input  logic [WIDTH-1:0]                               wdata,
   input  logic                                           re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
   output logic [WIDTH-1:0]                               rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/fsmt_ctrl.sv =====
// controller: sequences accept, table scan and result commit
module fsmt_ctrl import fsmt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_COMMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (stat.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   a_cmd_onehot0: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.start, cmd.scan, cmd.commit}))
      else $error("more than one command at once");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> stat.rsp_free)
      else $error("commit while result register occupied");

   a_start_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> cmd.scan)
      else $error("accepted transaction not followed by scan");

endmodule

// ===== hw/rtl/fsmt_datapath.sv =====
// datapath: item register, table scan, entry count and result register
module fsmt_datapath import fsmt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_payload,
   input  cmd_type  cmd,
   output stat_type stat,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_payload
);

   req_type           item_ff,     item_in;
   logic [CNT_W-1:0]  count_ff,    count_in;
   logic [CNT_W-1:0]  ptr_ff,      ptr_in;
   logic              pend_ff,     pend_in;
   logic [IDX_W-1:0]  pend_idx_ff, pend_idx_in;
   logic              hit_ff,      hit_in;
   logic [IDX_W-1:0]  hit_idx_ff,  hit_idx_in;
   logic [WORD_W-1:0] hit_word_ff, hit_word_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff,      rsp_in;

   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr;
   logic [WORD_W-1:0] ram_wdata;
   logic              ram_re;
   logic [WORD_W-1:0] ram_rdata;

   logic              match_now;
   logic              issue;
   logic              has_room;
   logic [WORD_W-1:0] new_word;
   rsp_type           result;

   fsmt_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_ENTRIES)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ptr_ff[IDX_W-1:0]),
      .rdata (ram_rdata)
   );

   assign match_now = pend_ff && (ram_rdata[31:24] == item_ff.drive_key);
   assign issue     = cmd.scan && !hit_ff && !match_now && (ptr_ff < count_ff);
   assign ram_re    = issue;
   assign has_room  = (count_ff < CNT_W'(MAX_ENTRIES));
   assign new_word  = {item_ff.drive_key, item_ff.new_supply_fail_mode,
                       item_ff.new_link_fail_mode, item_ff.new_comms_timeout};

   assign stat.scan_done = hit_ff || (!pend_ff && (ptr_ff >= count_ff));
   assign stat.rsp_free  = !rsp_valid_ff || rsp_ready;

   // result of the item being committed
   always_comb begin
      result    = '0;
      count_in  = count_ff;
      ram_we    = 1'b0;
      ram_waddr = hit_ff ? hit_idx_ff : count_ff[IDX_W-1:0];
      ram_wdata = new_word;
      unique case (item_ff.operation)
         OP_REGISTER: begin
            if (hit_ff || has_room) begin
               ram_we                        = cmd.commit;
               result.found_supply_fail_mode = new_word[23:20];
               result.found_link_fail_mode   = new_word[19:16];
               result.found_comms_timeout    = new_word[15:0];
               if (!hit_ff && cmd.commit) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end else begin
               result.status = STATUS_FULL;
            end
         end
         OP_EXECUTE, OP_LOOKUP: begin
            if (!hit_ff) begin
               result.status = STATUS_NOT_FOUND;
            end else begin
               result.found_supply_fail_mode = hit_word_ff[23:20];
               result.found_link_fail_mode   = hit_word_ff[19:16];
               result.found_comms_timeout    = hit_word_ff[15:0];
               if (item_ff.operation == OP_EXECUTE) begin
                  if (item_ff.power_lost) begin
                     result.apply_mode    = 1'b1;
                     result.selected_mode = hit_word_ff[23:20];
                  end else if (item_ff.comms_elapsed >= hit_word_ff[15:0]) begin
                     result.apply_mode    = 1'b1;
                     result.selected_mode = hit_word_ff[19:16];
                  end
               end
            end
         end
         default: begin
         end
      endcase
      result.entry_count = ENTRY_CNT_W'(count_in);
   end

   always_comb begin
      item_in     = item_ff;
      ptr_in      = ptr_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_word_in = hit_word_ff;
      if (cmd.start) begin
         item_in = req_payload;
         ptr_in  = '0;
         pend_in = 1'b0;
         hit_in  = 1'b0;
      end else if (cmd.scan) begin
         if (match_now && !hit_ff) begin
            hit_in      = 1'b1;
            hit_idx_in  = pend_idx_ff;
            hit_word_in = ram_rdata;
         end
         pend_in     = issue;
         pend_idx_in = ptr_ff[IDX_W-1:0];
         if (issue) begin
            ptr_in = ptr_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      pend_idx_ff <= pend_idx_in;
      hit_idx_ff  <= hit_idx_in;
      hit_word_ff <= hit_word_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count beyond table size");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (count_ff != $past(count_ff))
      |-> (count_ff == $past(count_ff) + CNT_W'(1)) && $past(cmd.commit))
      else $error("entry count moved other than by one append");

   a_hit_in_range: assert property (@(posedge clock) disable iff (reset)
      hit_ff |-> (CNT_W'(hit_idx_ff) < count_ff))
      else $error("matching entry outside the valid range");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= count_ff || !pend_ff)
      else $error("scan read beyond the valid entries");

endmodule

// ===== hw/rtl/failsafe_mode_table_top.sv =====
// top level of the fail-safe mode table: controller, datapath and entry store
//
// The block keeps up to MAX_ENTRIES (16) fail-safe entries keyed by actuator id,
// held in a small ram with registered read. Every transaction (register, execute
// or lookup) gives exactly one result. Each transaction walks the valid entries
// in order, one ram read per cycle, and the scan stops early at the first matching
// id. The result is written to the result register once the scan has ended and
// that register is free; the controller then returns to idle before it accepts
// the next transaction. One transaction is worked on at a time; the result
// register lets the next transaction be accepted while a finished result still
// waits to be taken. Entries are never removed; the count returns to zero only
// at reset.
module failsafe_mode_table_top import fsmt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   cmd_type  cmd;
   stat_type stat;

   fsmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fsmt_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== tb/failsafe_mode_table_top_tb.sv =====
// testbench for the fail-safe mode table: directed and random transactions checked against a predictor
`timescale 1ns / 100ps

module failsafe_mode_table_top_tb;
   import fsmt_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_WAIT = 18;
   localparam int REQ_W = $bits(req_type);

   typedef struct packed {
      logic [7:0]  id;
      logic [3:0]  supply_fail_mode;
      logic [3:0]  link_fail_mode;
      logic [15:0] comms_timeout;
   } failsafe_entry_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   failsafe_entry_type fs_table[MAX_ENTRIES];
   int unsigned        fs_count;
   rsp_type            pending_decisions[$];

   int cycle_count = 0;
   int n_errors = 0;
   int n_checked = 0;
   int n_full = 0;
   int n_not_found = 0;
   int n_applied = 0;
   int send_calm = 0;
   int recv_calm = 0;

   failsafe_mode_table_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t: run did not finish, %0d results outstanding", $realtime,
               pending_decisions.size());
      $display("FAIL failsafe_mode_table_top");
      $finish;
   end

   function automatic int draw_idle(ref int calm);
      if (calm == 0 && $urandom_range(0, 11) == 0)
         calm = $urandom_range(10, 40);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      return $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic bit id_known(input logic [7:0] id);
      for (int i = 0; i < fs_count; i++)
         if (fs_table[i].id == id)
            return 1'b1;
      return 1'b0;
   endfunction

   function automatic logic [7:0] fresh_id();
      logic [7:0] id;
      do
         id = 8'($urandom_range(0, 255));
      while (id_known(id));
      return id;
   endfunction

   function automatic req_type make_request(input logic [1:0] op, input logic [7:0] id,
                                            input logic [3:0] pl, input logic [3:0] cl,
                                            input logic [15:0] tmo, input logic lost,
                                            input logic [15:0] elapsed);
      req_type r;
      r.operation            = op;
      r.drive_key            = id;
      r.new_supply_fail_mode = pl;
      r.new_link_fail_mode   = cl;
      r.new_comms_timeout    = tmo;
      r.power_lost           = lost;
      r.comms_elapsed        = elapsed;
      return r;
   endfunction

   // updates the table copy and works out the result of one transaction
   task automatic predict_table_result(input req_type r, output rsp_type o);
      int                 hit;
      failsafe_entry_type e;
      o = '0;
      hit = -1;
      for (int i = 0; i < fs_count; i++)
         if (hit < 0 && fs_table[i].id == r.drive_key)
            hit = i;
      case (r.operation)
         OP_REGISTER: begin
            e = '{r.drive_key, r.new_supply_fail_mode, r.new_link_fail_mode,
                  r.new_comms_timeout};
            if (hit >= 0) begin
               fs_table[hit] = e;
            end else if (fs_count < MAX_ENTRIES) begin
               fs_table[fs_count] = e;
               fs_count++;
            end else begin
               o.status = STATUS_FULL;
            end
            if (o.status == STATUS_OK) begin
               o.found_supply_fail_mode = e.supply_fail_mode;
               o.found_link_fail_mode   = e.link_fail_mode;
               o.found_comms_timeout    = e.comms_timeout;
            end
         end
         OP_EXECUTE, OP_LOOKUP: begin
            if (hit < 0) begin
               o.status = STATUS_NOT_FOUND;
            end else begin
               e = fs_table[hit];
               o.found_supply_fail_mode = e.supply_fail_mode;
               o.found_link_fail_mode   = e.link_fail_mode;
               o.found_comms_timeout    = e.comms_timeout;
               if (r.operation == OP_EXECUTE) begin
                  if (r.power_lost) begin
                     o.apply_mode    = 1'b1;
                     o.selected_mode = e.supply_fail_mode;
                  end else if (r.comms_elapsed >= e.comms_timeout) begin
                     o.apply_mode    = 1'b1;
                     o.selected_mode = e.link_fail_mode;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      o.entry_count = ENTRY_CNT_W'(fs_count);
   endtask

   task automatic send_request(input req_type item);
      int      gap;
      rsp_type want;
      gap = draw_idle(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do
         @(posedge clock);
      while (!req_ready);
      predict_table_result(item, want);
      pending_decisions.push_back(want);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
         n_errors++;
      end
   endtask

   initial begin
      rsp_type want;
      int      stall;
      rsp_ready = 1'b0;
      forever begin
         stall = draw_idle(recv_calm);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do
            @(posedge clock);
         while (rsp_valid !== 1'b1);
         if (pending_decisions.size() == 0) begin
            $display("%0t: unexpected transaction, actual %p", $realtime, rsp_payload);
            n_errors++;
         end else begin
            want = pending_decisions.pop_front();
            n_checked++;
            if (want.status == STATUS_FULL)
               n_full++;
            if (want.status == STATUS_NOT_FOUND)
               n_not_found++;
            if (want.apply_mode)
               n_applied++;
            check_field("status", want.status, rsp_payload.status);
            check_field("apply_mode", want.apply_mode, rsp_payload.apply_mode);
            check_field("selected_mode", want.selected_mode, rsp_payload.selected_mode);
            check_field("found_supply_fail_mode", want.found_supply_fail_mode,
                        rsp_payload.found_supply_fail_mode);
            check_field("found_link_fail_mode", want.found_link_fail_mode,
                        rsp_payload.found_link_fail_mode);
            check_field("found_comms_timeout", want.found_comms_timeout,
                        rsp_payload.found_comms_timeout);
            check_field("entry_count", want.entry_count, rsp_payload.entry_count);
         end
      end
   end

   task automatic test_empty_table();
      send_request(make_request(OP_LOOKUP, 8'h00, 4'h0, 4'h0, 16'h0000, 1'b0, 16'h0000));
      send_request(make_request(OP_EXECUTE, 8'hFF, 4'hF, 4'hF, 16'hFFFF, 1'b1, 16'hFFFF));
      send_request(make_request(OP_EXECUTE, 8'h5A, 4'h3, 4'hC, 16'h0000, 1'b0, 16'h0000));
   endtask

   task automatic test_register_lookup();
      send_request(make_request(OP_REGISTER, 8'h00, 4'hF, 4'h0, 16'hFFFF, 1'b0, 16'h0000));
      send_request(make_request(OP_REGISTER, 8'hFF, 4'h0, 4'hF, 16'h0000, 1'b1, 16'hFFFF));
      send_request(make_request(OP_LOOKUP, 8'h00, 4'h9, 4'h6, 16'hAAAA, 1'b1, 16'h5555));
      send_request(make_request(OP_LOOKUP, 8'hFF, 4'h0, 4'h0, 16'h0000, 1'b0, 16'h0000));
      // overwrite of an existing id
      send_request(make_request(OP_REGISTER, 8'h00, 4'h5, 4'hA, 16'h04D2, 1'b0, 16'h0000));
      send_request(make_request(OP_LOOKUP, 8'h00, 4'h0, 4'h0, 16'h0000, 1'b0, 16'h0000));
   endtask

   task automatic test_execute_decisions();
      send_request(make_request(OP_EXECUTE, 8'hFF, 4'h0, 4'h0, 16'h0000, 1'b0, 16'h0000));
      send_request(make_request(OP_EXECUTE, 8'h00, 4'h0, 4'h0, 16'h0000, 1'b1, 16'h0000));
      send_request(make_request(OP_EXECUTE, 8'h00, 4'h0, 4'h0, 16'h0000, 1'b0, 16'h04D1));
      send_request(make_request(OP_EXECUTE, 8'h00, 4'h0, 4'h0, 16'h0000, 1'b0, 16'h04D2));
      send_request(make_request(OP_EXECUTE, 8'h00, 4'h0, 4'h0, 16'h0000, 1'b0, 16'hFFFF));
      send_request(make_request(OP_REGISTER, 8'h80, 4'hC, 4'h3, 16'hFFFF, 1'b0, 16'h0000));
      send_request(make_request(OP_EXECUTE, 8'h80, 4'h0, 4'h0, 16'h0000, 1'b0, 16'hFFFE));
      send_request(make_request(OP_EXECUTE, 8'h80, 4'h0, 4'h0, 16'h0000, 1'b0, 16'hFFFF));
   endtask

   task automatic test_unused_operation();
      send_request(make_request(OP_UNUSED, 8'hFF, 4'hF, 4'hF, 16'hFFFF, 1'b1, 16'hFFFF));
      send_request(make_request(OP_UNUSED, 8'h80, 4'h0, 4'h0, 16'h0000, 1'b0, 16'h0000));
   endtask

   task automatic test_random_traffic(input int n_items);
      req_type            r;
      failsafe_entry_type e;
      int                 pick;
      for (int n = 0; n < n_items; n++) begin
         r = req_type'(REQ_W'({$urandom, $urandom}));
         pick = $urandom_range(0, 99);
         if (pick < 30)
            r.operation = OP_REGISTER;
         else if (pick < 65)
            r.operation = OP_EXECUTE;
         else if (pick < 95)
            r.operation = OP_LOOKUP;
         else
            r.operation = OP_UNUSED;
         if (fs_count > 0 && $urandom_range(0, 9) < 7) begin
            e = fs_table[$urandom_range(0, fs_count - 1)];
            r.drive_key = e.id;
            // comms elapsed at or next to the stored timeout, at either extreme, or left random
            case ($urandom_range(0, 5))
               0: r.comms_elapsed = e.comms_timeout;
               1: r.comms_elapsed = e.comms_timeout - 16'd1;
               2: r.comms_elapsed = e.comms_timeout + 16'd1;
               3: r.comms_elapsed = 16'h0000;
               4: r.comms_elapsed = 16'hFFFF;
               default: begin
               end
            endcase
         end
         case ($urandom_range(0, 7))
            0: r.new_comms_timeout = 16'h0000;
            1: r.new_comms_timeout = 16'hFFFF;
            2: r.new_comms_timeout = 16'($urandom_range(0, 8));
            default: begin
            end
         endcase
         send_request(r);
      end
   endtask

   task automatic test_full_table();
      while (fs_count < MAX_ENTRIES)
         send_request(make_request(OP_REGISTER, fresh_id(), 4'($urandom), 4'($urandom),
                                   16'($urandom), 1'b0, 16'h0000));
      send_request(make_request(OP_REGISTER, fresh_id(), 4'hF, 4'hF, 16'hFFFF, 1'b1, 16'hFFFF));
      // a known id still updates on a full table
      send_request(make_request(OP_REGISTER, fs_table[MAX_ENTRIES - 1].id, 4'h7, 4'h8,
                                16'h0010, 1'b0, 16'h0000));
      send_request(make_request(OP_LOOKUP, fresh_id(), 4'h0, 4'h0, 16'h0000, 1'b0, 16'h0000));
      send_request(make_request(OP_EXECUTE, fs_table[MAX_ENTRIES - 1].id, 4'h0, 4'h0,
                                16'h0000, 1'b0, 16'h0010));
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      fs_count    = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_register_lookup();
      test_execute_decisions();
      test_unused_operation();
      test_random_traffic(550);
      test_full_table();
      test_random_traffic(550);

      req_valid <= 1'b0;
      while (pending_decisions.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      $display("checked %0d results with %0d entries held at the end", n_checked, fs_count);
      $display("%0d table full, %0d not found, %0d modes applied", n_full, n_not_found,
               n_applied);
      if (n_errors == 0) begin
         $display("PASS failsafe_mode_table_top");
      end else begin
         $display("%0d mismatches", n_errors);
         $display("FAIL failsafe_mode_table_top");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/fsmt_pkg.sv
hw/rtl/fsmt_ram.sv
hw/rtl/fsmt_ctrl.sv
hw/rtl/fsmt_datapath.sv
hw/rtl/failsafe_mode_table_top.sv
tb/failsafe_mode_table_top_tb.sv
